FILE: rtl/fprf_pkg.sv
// Shared types, widths and constants of the fixed-point FIR ring filter.
// Holds the Q11 coefficient table, configuration register indexes, FSM state
// and the command/status structs between controller and datapath. No dependencies.
package fprf_pkg;

  // Ring depth and fixed-point format
  localparam int MAX_TAPS  = 59;
  localparam int FRAC_BITS = 11;

  // Field and internal widths
  localparam int SAMPLE_W   = 13;
  localparam int COEF_W     = 12;
  localparam int TAP_W      = 6;
  localparam int ADDR_W     = $clog2(MAX_TAPS);
  localparam int ACC_W      = 32;
  localparam int NORM_W     = 32;
  localparam int OUT_W      = ACC_W - FRAC_BITS;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int IN_DATA_W  = ((SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // Centre of the coefficient table
  localparam logic [TAP_W-1:0] TAP_CENTRE = TAP_W'(MAX_TAPS / 2);
  localparam logic [ADDR_W-1:0] RING_LAST = ADDR_W'(MAX_TAPS - 1);

  // Register reset values
  localparam logic [TAP_W-1:0]  TAP_COUNT_RST  = TAP_W'(50);
  localparam logic [NORM_W-1:0] NORM_SCALE_RST = NORM_W'(2048);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORM_SCALE = 1'b1;

  // Symmetric low-pass kernel in Q11, zero padded at both ends
  localparam logic signed [COEF_W-1:0] COEF_TABLE [MAX_TAPS] = '{
    12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0,
    12'sd9, 12'sd15, -12'sd4, -12'sd14, 12'sd6, 12'sd0, -12'sd19, 12'sd8,
    12'sd9, -12'sd27, 12'sd6, 12'sd23, -12'sd36, -12'sd2, 12'sd45, -12'sd46,
    -12'sd22, 12'sd81, -12'sd53, -12'sd69, 12'sd154, -12'sd59, -12'sd246,
    12'sd589, 12'sd1304, 12'sd589, -12'sd246, -12'sd59, 12'sd154, -12'sd69,
    -12'sd53, 12'sd81, -12'sd22, -12'sd46, 12'sd45, -12'sd2, -12'sd36,
    12'sd23, 12'sd6, -12'sd27, 12'sd9, 12'sd8, -12'sd19, 12'sd0, 12'sd6,
    -12'sd14, -12'sd4, 12'sd15, 12'sd9,
    12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0
  };

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_SCALE,
    ST_STORE
  } fprf_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic start;     // take the input sample, reset tap walk and accumulator
    logic step;      // issue one tap read
    logic scale;     // apply normalization gain
    logic load_out;  // move the scaled sum into the output register
  } fprf_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic no_taps;
    logic last_tap;
    logic pipe_busy;
    logic out_free;
  } fprf_sts_t;

endpackage

FILE: rtl/fprf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module fprf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/fprf_ctrl.sv
// Sequencer of the FIR ring filter: walks each sample through tap issue (skipped
// when there are no taps), pipeline drain, scaling and output store. Depends on fprf_pkg.
module fprf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  fprf_pkg::fprf_sts_t sts,
  output fprf_pkg::fprf_cmd_t cmd
);
  import fprf_pkg::*;

  fprf_state_t state_r;
  fprf_state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = sts.no_taps ? ST_DRAIN : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (sts.last_tap) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        state_nxt = ST_STORE;
      end
      ST_STORE: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_tready    = 1'b0;
    cmd          = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.start = in_tvalid;
      end
      ST_ISSUE: begin
        cmd.step = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
      end
      ST_STORE: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/fprf_dp.sv
// Datapath of the FIR ring filter: configuration registers, sample history
// ring with valid bits, tap multiply-accumulate, scaling and output register.
// Depends on fprf_pkg and fprf_ram.
module fprf_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fprf_pkg::fprf_cmd_t                 cmd,
  output fprf_pkg::fprf_sts_t                 sts,
  input  logic signed [fprf_pkg::SAMPLE_W-1:0] sample,
  input  logic                                cfg_we,
  input  logic [fprf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fprf_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic signed [fprf_pkg::OUT_W-1:0]   filtered
);
  import fprf_pkg::*;

  // Configuration registers
  logic [TAP_W-1:0]  tap_count_r;
  logic [NORM_W-1:0] norm_scale_r;

  // Ring state
  logic [ADDR_W-1:0]   newest_r;
  logic [ADDR_W-1:0]   wr_pos;
  logic [MAX_TAPS-1:0] hist_vld_r;

  // Tap walk
  logic [ADDR_W-1:0] rd_addr_r;
  logic [TAP_W-1:0]  tap_idx_r;
  logic [TAP_W-1:0]  coef_k_r;
  logic [TAP_W-1:0]  q_eff;
  logic [TAP_W-1:0]  half;
  logic [TAP_W-1:0]  window;

  // Pipeline
  logic                       s1_vld_r;
  logic                       s1_hval_r;
  logic signed [COEF_W-1:0]   s1_coef_r;
  logic [SAMPLE_W-1:0]        ram_rdata;
  logic signed [SAMPLE_W-1:0] s1_sample;
  logic                       p_vld_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [PROD_W-1:0]   prod_nxt;
  logic [ACC_W-1:0]           acc_r;
  logic [ACC_W-1:0]           acc_nxt;
  logic [ACC_W-1:0]           sc_r;
  logic [ACC_W-1:0]           sc_nxt;

  // Output register
  logic                    out_tvalid_r;
  logic signed [OUT_W-1:0] out_data_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r  <= TAP_COUNT_RST;
      norm_scale_r <= NORM_SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TAP_COUNT:  tap_count_r  <= cfg_data[TAP_W-1:0];
        CFG_NORM_SCALE: norm_scale_r <= cfg_data[NORM_W-1:0];
      endcase
    end
  end

  // Saturate tap count and derive the centred window
  assign q_eff  = (tap_count_r > TAP_W'(MAX_TAPS)) ? TAP_W'(MAX_TAPS) : tap_count_r;
  assign half   = q_eff >> 1;
  assign window = {half[TAP_W-2:0], 1'b0};

  // Newest sample goes one slot below the previous one
  assign wr_pos = (newest_r == '0) ? RING_LAST : newest_r - ADDR_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      newest_r   <= '0;
      hist_vld_r <= '0;
    end else if (cmd.start) begin
      newest_r           <= wr_pos;
      hist_vld_r[wr_pos] <= 1'b1;
    end
  end

  fprf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_TAPS)
  ) u_hist (
    .clk   (clk),
    .we    (cmd.start),
    .waddr (wr_pos),
    .wdata (sample),
    .re    (cmd.step),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  // Walk ring address, tap index and table position
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rd_addr_r <= wr_pos;
      tap_idx_r <= '0;
      coef_k_r  <= TAP_CENTRE - half;
    end else if (cmd.step) begin
      rd_addr_r <= (rd_addr_r == RING_LAST) ? '0 : rd_addr_r + ADDR_W'(1);
      tap_idx_r <= tap_idx_r + TAP_W'(1);
      coef_k_r  <= coef_k_r + TAP_W'(1);
    end
  end

  // Stage 1: coefficient and history valid alongside the RAM read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      s1_hval_r <= hist_vld_r[rd_addr_r];
      s1_coef_r <= (tap_idx_r < window) ? COEF_TABLE[coef_k_r[ADDR_W-1:0]] : '0;
    end
  end

  // Stage 2: multiply; unwritten ring slots read as zero
  assign s1_sample = s1_hval_r ? $signed(ram_rdata) : '0;
  assign prod_nxt  = s1_sample * s1_coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      prod_r <= prod_nxt;
    end
  end

  // Stage 3: drop fraction bits and accumulate with wrap
  assign acc_nxt = acc_r + ACC_W'(prod_r >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc_r <= '0;
    end else if (p_vld_r) begin
      acc_r <= acc_nxt;
    end
  end

  // Normalization gain, low word kept
  assign sc_nxt = acc_r * norm_scale_r;

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      sc_r <= sc_nxt;
    end
  end

  // Output register: load the shifted result, hold until transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= $signed(sc_r[ACC_W-1:FRAC_BITS]);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign filtered   = out_data_r;

  // Status
  assign sts.no_taps   = (q_eff == '0);
  assign sts.last_tap  = (tap_idx_r == q_eff - TAP_W'(1));
  assign sts.pipe_busy = s1_vld_r | p_vld_r;
  assign sts.out_free  = !out_tvalid_r || out_tready;

endmodule

FILE: rtl/fixed_point_fir_ring_filter_core.sv
// Fixed-point FIR filter over a 59-entry sample history ring, Q11 taps.
// Tap count q is capped at 59; one tap read per cycle from the history RAM while
// taps are issued. The output register lets the next sample enter while a result
// waits. Synchronous active-low reset clears the ring valid bits, ring pointer,
// pipeline and output valid flags and controller state, and loads register
// defaults.
module fixed_point_fir_ring_filter_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [fprf_pkg::IN_DATA_W-1:0]       in_tdata,   // [12:0] sample
  // Result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [fprf_pkg::OUT_DATA_W-1:0]      out_tdata,  // [20:0] filtered
  // Configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fprf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fprf_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import fprf_pkg::*;

  fprf_cmd_t           cmd;
  fprf_sts_t           sts;
  logic signed [OUT_W-1:0] filtered;

  // Configuration is always taken
  assign cfg_ready = 1'b1;

  fprf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fprf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .sample     ($signed(in_tdata[SAMPLE_W-1:0])),
    .cfg_we     (cfg_valid & cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .filtered   (filtered)
  );

  // Pad the result to whole bytes
  assign out_tdata = {{(OUT_DATA_W - OUT_W){1'b0}}, filtered};

endmodule
